[rtl/core/segment_pair_collision_test_defines.svh]
// ---------------------------------------------------------------------------
// assertion macros for the segment pair collision test
// ---------------------------------------------------------------------------
`ifndef SEGMENT_PAIR_COLLISION_TEST_DEFINES_SVH
`define SEGMENT_PAIR_COLLISION_TEST_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SEGPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define SEGPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/segpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// segpc_pkg
// shared types of the segment pair collision test
// ---------------------------------------------------------------------------
package segpc_pkg;

   // outcome of the ratio checks for one segment pair
   typedef struct packed {
      logic den_zero;
      logic s_in_unit;
      logic t_in_unit;
   } verdict_type;

endpackage
`default_nettype wire

[rtl/core/segpc_cross.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// segpc_cross
// direction vectors, start offset and the six cross-product terms
// ---------------------------------------------------------------------------
module segpc_cross #(
   parameter int COORD_BITS = 16
) (
   input  wire logic signed [COORD_BITS-1:0]   first_start_x,
   input  wire logic signed [COORD_BITS-1:0]   first_start_y,
   input  wire logic signed [COORD_BITS-1:0]   first_end_x,
   input  wire logic signed [COORD_BITS-1:0]   first_end_y,
   input  wire logic signed [COORD_BITS-1:0]   second_start_x,
   input  wire logic signed [COORD_BITS-1:0]   second_start_y,
   input  wire logic signed [COORD_BITS-1:0]   second_end_x,
   input  wire logic signed [COORD_BITS-1:0]   second_end_y,
   output logic signed [2*COORD_BITS+1:0]      den_a,
   output logic signed [2*COORD_BITS+1:0]      den_b,
   output logic signed [2*COORD_BITS+1:0]      snum_a,
   output logic signed [2*COORD_BITS+1:0]      snum_b,
   output logic signed [2*COORD_BITS+1:0]      tnum_a,
   output logic signed [2*COORD_BITS+1:0]      tnum_b
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * COORD_BITS + 2;

   logic signed [DW-1:0] s1x;
   logic signed [DW-1:0] s1y;
   logic signed [DW-1:0] s2x;
   logic signed [DW-1:0] s2y;
   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;

   assign s1x = DW'(first_end_x) - DW'(first_start_x);
   assign s1y = DW'(first_end_y) - DW'(first_start_y);
   assign s2x = DW'(second_end_x) - DW'(second_start_x);
   assign s2y = DW'(second_end_y) - DW'(second_start_y);
   assign dx  = DW'(first_start_x) - DW'(second_start_x);
   assign dy  = DW'(first_start_y) - DW'(second_start_y);

   // operands sign-extend to the product width, so each product is exact
   assign den_a  = PW'(s1x) * PW'(s2y);
   assign den_b  = PW'(s2x) * PW'(s1y);
   assign snum_a = PW'(s1x) * PW'(dy);
   assign snum_b = PW'(s1y) * PW'(dx);
   assign tnum_a = PW'(s2x) * PW'(dy);
   assign tnum_b = PW'(s2y) * PW'(dx);

endmodule
`default_nettype wire

[rtl/core/segpc_judge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// segpc_judge
// forms denominator and numerators and checks both ratios against [0,1]
// ---------------------------------------------------------------------------
module segpc_judge #(
   parameter int COORD_BITS = 16
) (
   input  wire logic signed [2*COORD_BITS+1:0] den_a,
   input  wire logic signed [2*COORD_BITS+1:0] den_b,
   input  wire logic signed [2*COORD_BITS+1:0] snum_a,
   input  wire logic signed [2*COORD_BITS+1:0] snum_b,
   input  wire logic signed [2*COORD_BITS+1:0] tnum_a,
   input  wire logic signed [2*COORD_BITS+1:0] tnum_b,
   output segpc_pkg::verdict_type              verdict
);

   localparam int NW = 2 * COORD_BITS + 3;

   logic signed [NW-1:0] den;
   logic signed [NW-1:0] snum;
   logic signed [NW-1:0] tnum;
   logic                 den_neg;
   logic                 s_pos;
   logic                 s_nonpos;
   logic                 t_pos;
   logic                 t_nonpos;

   assign den  = NW'(den_a) - NW'(den_b);
   assign snum = NW'(snum_a) - NW'(snum_b);
   assign tnum = NW'(tnum_a) - NW'(tnum_b);

   assign den_neg  = den[NW-1];
   assign s_pos    = !snum[NW-1];
   assign s_nonpos = snum[NW-1] || (snum == NW'(0));
   assign t_pos    = !tnum[NW-1];
   assign t_nonpos = tnum[NW-1] || (tnum == NW'(0));

   // num/den in [0,1] without dividing: same sign as den and no larger in magnitude
   always_comb begin
      verdict.den_zero = (den == NW'(0));
      if (den_neg) begin
         verdict.s_in_unit = s_nonpos && (snum >= den);
         verdict.t_in_unit = t_nonpos && (tnum >= den);
      end else begin
         verdict.s_in_unit = s_pos && (snum <= den);
         verdict.t_in_unit = t_pos && (tnum <= den);
      end
   end

endmodule
`default_nettype wire

[rtl/core/segment_pair_collision_test.sv]
`timescale 1ns / 1ps
`default_nettype none
// result path: a run's last pair passes the input register, then the product register, then the result register
// throughput: one pair per cycle, set by the product register stage feeding the
// subtract and compare stage; only a run end waits on an unread result
// reset: clears all stage valids, the pending result and the sticky hit flag
// ---------------------------------------------------------------------------
// segment_pair_collision_test
// two-segment intersection test with a sticky hit flag per run
// ---------------------------------------------------------------------------
`include "segment_pair_collision_test_defines.svh"

module segment_pair_collision_test #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_first_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_first_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_first_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_first_end_y,
   input  wire logic signed [COORD_BITS-1:0] req_second_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_second_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_second_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_second_end_y,
   input  wire logic                         req_last_pair,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_any_hit
);

   localparam int PW = 2 * COORD_BITS + 2;

   // input register
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic signed [COORD_BITS-1:0] s1_p0x_ff;
   logic signed [COORD_BITS-1:0] s1_p0y_ff;
   logic signed [COORD_BITS-1:0] s1_p1x_ff;
   logic signed [COORD_BITS-1:0] s1_p1y_ff;
   logic signed [COORD_BITS-1:0] s1_p2x_ff;
   logic signed [COORD_BITS-1:0] s1_p2y_ff;
   logic signed [COORD_BITS-1:0] s1_p3x_ff;
   logic signed [COORD_BITS-1:0] s1_p3y_ff;
   logic                         s1_last_ff;

   // product register
   logic                         s2_valid_ff;
   logic                         s2_valid_in;
   logic signed [PW-1:0]         den_a_in;
   logic signed [PW-1:0]         den_b_in;
   logic signed [PW-1:0]         snum_a_in;
   logic signed [PW-1:0]         snum_b_in;
   logic signed [PW-1:0]         tnum_a_in;
   logic signed [PW-1:0]         tnum_b_in;
   logic signed [PW-1:0]         den_a_ff;
   logic signed [PW-1:0]         den_b_ff;
   logic signed [PW-1:0]         snum_a_ff;
   logic signed [PW-1:0]         snum_b_ff;
   logic signed [PW-1:0]         tnum_a_ff;
   logic signed [PW-1:0]         tnum_b_ff;
   logic                         s2_last_ff;

   // run state and result register
   logic                         hit_seen_ff;
   logic                         hit_seen_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         rsp_any_hit_ff;

   segpc_pkg::verdict_type       verdict;
   logic                         pair_hit;
   logic                         run_hit;
   logic                         out_free;
   logic                         s2_go;
   logic                         s2_ready;
   logic                         s1_go;
   logic                         s1_ready;
   logic                         req_take;

   // handshake between stages; a pair that ends no run leaves the product stage without waiting on the output
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s2_go    = s2_valid_ff && (!s2_last_ff || out_free);
   assign s2_ready = !s2_valid_ff || s2_go;
   assign s1_go    = s1_valid_ff && s2_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_take = req_valid && s1_ready;

   assign req_ready   = s1_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_any_hit = rsp_any_hit_ff;

   segpc_cross #(
      .COORD_BITS(COORD_BITS)
   ) u_cross (
      .first_start_x  (s1_p0x_ff),
      .first_start_y  (s1_p0y_ff),
      .first_end_x    (s1_p1x_ff),
      .first_end_y    (s1_p1y_ff),
      .second_start_x (s1_p2x_ff),
      .second_start_y (s1_p2y_ff),
      .second_end_x   (s1_p3x_ff),
      .second_end_y   (s1_p3y_ff),
      .den_a          (den_a_in),
      .den_b          (den_b_in),
      .snum_a         (snum_a_in),
      .snum_b         (snum_b_in),
      .tnum_a         (tnum_a_in),
      .tnum_b         (tnum_b_in)
   );

   segpc_judge #(
      .COORD_BITS(COORD_BITS)
   ) u_judge (
      .den_a   (den_a_ff),
      .den_b   (den_b_ff),
      .snum_a  (snum_a_ff),
      .snum_b  (snum_b_ff),
      .tnum_a  (tnum_a_ff),
      .tnum_b  (tnum_b_ff),
      .verdict (verdict)
   );

   // parallel or degenerate segments never hit
   assign pair_hit = !verdict.den_zero && verdict.s_in_unit && verdict.t_in_unit;
   assign run_hit  = hit_seen_ff || pair_hit;

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !s1_go);
      s2_valid_in  = s1_go || (s2_valid_ff && !s2_go);
      hit_seen_in  = hit_seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s2_go) begin
         if (s2_last_ff) begin
            hit_seen_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end else begin
            hit_seen_in = run_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         hit_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         hit_seen_ff  <= hit_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_p0x_ff  <= req_first_start_x;
         s1_p0y_ff  <= req_first_start_y;
         s1_p1x_ff  <= req_first_end_x;
         s1_p1y_ff  <= req_first_end_y;
         s1_p2x_ff  <= req_second_start_x;
         s1_p2y_ff  <= req_second_start_y;
         s1_p3x_ff  <= req_second_end_x;
         s1_p3y_ff  <= req_second_end_y;
         s1_last_ff <= req_last_pair;
      end
      if (s1_go) begin
         den_a_ff   <= den_a_in;
         den_b_ff   <= den_b_in;
         snum_a_ff  <= snum_a_in;
         snum_b_ff  <= snum_b_in;
         tnum_a_ff  <= tnum_a_in;
         tnum_b_ff  <= tnum_b_in;
         s2_last_ff <= s1_last_ff;
      end
      if (s2_go && s2_last_ff) begin
         rsp_any_hit_ff <= run_hit;
      end
   end

   // a run end must never overwrite a result that is still waiting
   `SEGPC_ASSERT_NOW(a_no_result_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !(s2_go && s2_last_ff), "run end overwrote a pending result")
   // a run end always raises a result and clears the sticky flag
   `SEGPC_ASSERT_NEXT(a_run_end_result, clock, reset, s2_go && s2_last_ff, rsp_valid_ff && !hit_seen_ff, "run end did not produce a result")
   // a pair in the input register stays while the product stage is blocked
   `SEGPC_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s2_ready, s1_valid_ff, "input stage lost a pair while stalled")
   // a new result only appears after a run end left the product stage
   `SEGPC_ASSERT_NEXT(a_result_source, clock, reset, !rsp_valid_ff && !(s2_go && s2_last_ff), !rsp_valid_ff, "result appeared without a run end")

endmodule
`default_nettype wire

[tb/sv/segment_pair_collision_test_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// segment_pair_collision_test_test
// self-checking bench: runs of segment pairs go in, each run's any-hit flag
// is predicted with exact wide integer cross products and checked in order
// ---------------------------------------------------------------------------
module segment_pair_collision_test_test;

   localparam int COORD_BITS = 16;
   localparam int WIDE_BITS  = 2 * COORD_BITS + 4;
   localparam int LONG_HOLD  = 300;
   localparam int IDLE_LIMIT = 4000;
   localparam int TAIL_WAIT  = 8;

   typedef logic signed [COORD_BITS-1:0] coord_t;
   typedef logic signed [WIDE_BITS-1:0]  wide_t;

   typedef struct {
      coord_t first_start_x;
      coord_t first_start_y;
      coord_t first_end_x;
      coord_t first_end_y;
      coord_t second_start_x;
      coord_t second_start_y;
      coord_t second_end_x;
      coord_t second_end_y;
      logic   last_pair;
   } seg_pair_t;

   class hit_scoreboard;
      bit run_hit = 1'b0;   // sticky or of hits since the last reported run
      bit expected_hits[$];
      int mismatches     = 0;
      int pairs_seen     = 0;
      int runs_checked   = 0;
      int runs_hit       = 0;
      int zero_den_pairs = 0;

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t mismatch: %s", $time, msg);
         end
      endfunction

      // num/den within [0,1], den nonzero
      function bit ratio_in_unit(wide_t num, wide_t den);
         if (den > 0) begin
            return (num >= 0) && (num <= den);
         end
         return (num <= 0) && (num >= den);
      endfunction

      function bit pair_intersects(seg_pair_t p);
         wide_t s1x, s1y, s2x, s2y, ox, oy, den, s_num, t_num;
         s1x   = wide_t'(p.first_end_x) - wide_t'(p.first_start_x);
         s1y   = wide_t'(p.first_end_y) - wide_t'(p.first_start_y);
         s2x   = wide_t'(p.second_end_x) - wide_t'(p.second_start_x);
         s2y   = wide_t'(p.second_end_y) - wide_t'(p.second_start_y);
         ox    = wide_t'(p.first_start_x) - wide_t'(p.second_start_x);
         oy    = wide_t'(p.first_start_y) - wide_t'(p.second_start_y);
         den   = s1x * s2y - s2x * s1y;
         s_num = s1x * oy - s1y * ox;
         t_num = s2x * oy - s2y * ox;
         // parallel, collinear or degenerate: never a hit
         if (den == 0) begin
            zero_den_pairs++;
            return 1'b0;
         end
         return ratio_in_unit(s_num, den) && ratio_in_unit(t_num, den);
      endfunction

      function void note_pair(seg_pair_t p);
         bit hit;
         hit = pair_intersects(p);
         pairs_seen++;
         if (p.last_pair) begin
            expected_hits.push_back(run_hit | hit);
            run_hit = 1'b0;
         end else begin
            run_hit = run_hit | hit;
         end
      endfunction

      function void check_result(logic got);
         bit want;
         if (expected_hits.size() == 0) begin
            flag($sformatf("any_hit %0b arrived with no run pending", got));
            return;
         end
         want = expected_hits.pop_front();
         runs_checked++;
         if (got === 1'b1) begin
            runs_hit++;
         end
         if (got !== want) begin
            flag($sformatf("run %0d any_hit expected %0b got %0b", runs_checked, want, got));
         end
      endfunction

      function int pending();
         return expected_hits.size();
      endfunction

      function void close_out();
         if (expected_hits.size() != 0) begin
            flag($sformatf("%0d run results never arrived", expected_hits.size()));
         end
      endfunction
   endclass

   logic   clock;
   logic   reset              = 1'b1;
   logic   req_valid          = 1'b0;
   logic   req_ready;
   coord_t req_first_start_x  = '0;
   coord_t req_first_start_y  = '0;
   coord_t req_first_end_x    = '0;
   coord_t req_first_end_y    = '0;
   coord_t req_second_start_x = '0;
   coord_t req_second_start_y = '0;
   coord_t req_second_end_x   = '0;
   coord_t req_second_end_y   = '0;
   logic   req_last_pair      = 1'b0;
   logic   rsp_valid;
   logic   rsp_ready          = 1'b0;
   logic   rsp_any_hit;

   hit_scoreboard sb;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   segment_pair_collision_test #(
      .COORD_BITS(COORD_BITS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_first_start_x  (req_first_start_x),
      .req_first_start_y  (req_first_start_y),
      .req_first_end_x    (req_first_end_x),
      .req_first_end_y    (req_first_end_y),
      .req_second_start_x (req_second_start_x),
      .req_second_start_y (req_second_start_y),
      .req_second_end_x   (req_second_end_x),
      .req_second_end_y   (req_second_end_y),
      .req_last_pair      (req_last_pair),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_any_hit        (rsp_any_hit)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // beat monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_pair('{req_first_start_x, req_first_start_y, req_first_end_x,
                           req_first_end_y, req_second_start_x, req_second_start_y,
                           req_second_end_x, req_second_end_y, req_last_pair});
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_any_hit);
         end
      end
   end

   // ends the run when no beat moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("no beat moved for %0d cycles", IDLE_LIMIT);
      $display("[segment_pair_collision_test] ERROR");
      $finish;
   end

   task automatic send_pair(seg_pair_t p);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_first_start_x  <= p.first_start_x;
      req_first_start_y  <= p.first_start_y;
      req_first_end_x    <= p.first_end_x;
      req_first_end_y    <= p.first_end_y;
      req_second_start_x <= p.second_start_x;
      req_second_start_y <= p.second_start_y;
      req_second_end_x   <= p.second_end_x;
      req_second_end_y   <= p.second_end_y;
      req_last_pair      <= p.last_pair;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_xy(int ax, int ay, int bx, int by,
                          int cx, int cy, int dx, int dy, bit last);
      send_pair('{coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by),
                  coord_t'(cx), coord_t'(cy), coord_t'(dx), coord_t'(dy), last});
   endtask

   // sender goes quiet until every noted run has reported
   task automatic wait_all_reported();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic coord_t any_coord();
      return coord_t'($urandom_range(0, 65535));
   endfunction

   function automatic coord_t near_coord();
      return coord_t'(int'($urandom_range(0, 48)) - 24);
   endfunction

   function automatic coord_t rim_coord();
      case ($urandom_range(0, 7))
         0: return coord_t'(-32768);
         1: return coord_t'(-32767);
         2: return coord_t'(-1);
         3: return coord_t'(0);
         4: return coord_t'(1);
         5: return coord_t'(32766);
         6: return coord_t'(32767);
         default: return any_coord();
      endcase
   endfunction

   function automatic seg_pair_t random_pair(bit last);
      seg_pair_t p;
      int        ox, oy, k;
      p.first_start_x  = near_coord();
      p.first_start_y  = near_coord();
      p.first_end_x    = near_coord();
      p.first_end_y    = near_coord();
      p.second_start_x = near_coord();
      p.second_start_y = near_coord();
      p.second_end_x   = near_coord();
      p.second_end_y   = near_coord();
      p.last_pair      = last;
      case ($urandom_range(0, 9))
         0, 1: begin
            p.first_start_x  = any_coord();
            p.first_start_y  = any_coord();
            p.first_end_x    = any_coord();
            p.first_end_y    = any_coord();
            p.second_start_x = any_coord();
            p.second_start_y = any_coord();
            p.second_end_x   = any_coord();
            p.second_end_y   = any_coord();
         end
         5: begin
            // second segment parallel to the first, sometimes on the same line
            ox = int'($urandom_range(0, 8)) - 4;
            oy = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 8)) - 4;
            k  = int'($urandom_range(0, 4)) - 2;
            p.second_start_x = coord_t'(p.first_start_x + ox);
            p.second_start_y = coord_t'(p.first_start_y + oy);
            p.second_end_x   = coord_t'(p.second_start_x + k * (p.first_end_x - p.first_start_x));
            p.second_end_y   = coord_t'(p.second_start_y + k * (p.first_end_y - p.first_start_y));
         end
         6: begin
            // shared endpoint
            if ($urandom_range(0, 1)) begin
               p.second_start_x = p.first_end_x;
               p.second_start_y = p.first_end_y;
            end else begin
               p.second_end_x = p.first_start_x;
               p.second_end_y = p.first_start_y;
            end
         end
         7: begin
            // one segment shrunk to a point
            p.first_end_x = p.first_start_x;
            p.first_end_y = p.first_start_y;
         end
         8: begin
            p.first_start_x  = rim_coord();
            p.first_start_y  = rim_coord();
            p.first_end_x    = rim_coord();
            p.first_end_y    = rim_coord();
            p.second_start_x = rim_coord();
            p.second_start_y = rim_coord();
            p.second_end_x   = rim_coord();
            p.second_end_y   = rim_coord();
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic run_phase(int idle_pct, int stall_pct, int n_pairs);
      int sent, run_len;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_pairs) begin
         run_len = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
         for (int i = 0; i < run_len; i++) begin
            send_pair(random_pair(i == run_len - 1));
            sent++;
         end
      end
      wait_all_reported();
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pairs, each a run of its own unless noted
      send_xy(0, 0, 10, 10, 0, 10, 10, 0, 1);                    // plain crossing
      send_xy(0, 0, 1, 0, 5, 5, 6, 7, 1);                        // clear miss
      send_xy(0, 0, 10, 0, 0, 1, 10, 1, 1);                      // parallel
      send_xy(0, 0, 10, 0, 5, 0, 15, 0, 1);                      // collinear overlap
      send_xy(3, 3, 3, 3, 0, 0, 6, 6, 1);                        // point on a segment
      send_xy(0, 0, 5, 5, 5, 5, 10, 0, 1);                       // endpoints touch
      send_xy(0, 0, 10, 0, 5, 0, 5, 7, 1);                       // s touches zero
      send_xy(0, 0, 10, 0, 5, 7, 5, 0, 1);                       // s touches one
      send_xy(0, 0, 4, 4, 5, 0, 0, 5, 1);                        // crossing inside both segments
      send_xy(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 1);
      send_xy(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767, 1);
      send_xy(-32768, -32768, 32767, 32766, 32767, 32767, -32768, 32767, 1);
      send_xy(32767, -32768, -32768, 32767, -1, -1, 0, 0, 1);
      send_xy(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845, 1);
      // sticky hit in the middle of a run, then a clean run after it
      send_xy(0, 0, 1, 0, 5, 5, 6, 7, 0);
      send_xy(0, 0, 10, 10, 0, 10, 10, 0, 0);
      send_xy(0, 0, 10, 0, 0, 1, 10, 1, 0);
      send_xy(0, 0, 1, 0, 5, 5, 6, 7, 1);
      send_xy(0, 0, 10, 0, 0, 1, 10, 1, 0);
      send_xy(0, 0, 1, 0, 5, 5, 6, 7, 1);
      wait_all_reported();

      run_phase(0, 0, 240);

      // receiver holds off while single-pair runs keep coming, then drain
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_requests = hold_requests + 1;
      for (int i = 0; i < 40; i++) begin
         send_pair(random_pair(1'b1));
      end
      wait_all_reported();

      run_phase(81, 0, 220);
      run_phase(0, 81, 220);
      run_phase(20, 20, 220);

      wait_all_reported();
      repeat (TAIL_WAIT) @(posedge clock);
      sb.close_out();

      $display("%0d segment pairs in %0d runs, %0d runs flagged a hit, %0d pairs had a zero denominator",
               sb.pairs_seen, sb.runs_checked, sb.runs_hit, sb.zero_den_pairs);
      $display("idling mixes covered: none, sender, receiver, both, plus a long receiver hold; %0d mismatches",
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("[segment_pair_collision_test] OK");
      end else begin
         $display("[segment_pair_collision_test] ERROR");
      end
      $finish;
   end

endmodule
